// File: sv/pkst_pkg.sv
// Shared types and constants for the port keyed session table.
// Holds the operation codes, sequencer states and entry/result records.
// No dependencies.
package pkst_pkg;

   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 144;
   localparam int OP_W       = 2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_UPDATE = 2'd2,
      OP_FETCH  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_FIND,
      ST_ADD_WALK,
      ST_RM_START,
      ST_RM_WALK,
      ST_RM_FIX,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [15:0] key;
      logic [15:0] peer_port;
      logic [31:0] peer_addr;
      logic [30:0] duration;
      logic [30:0] process_id;
      logic [30:0] client_id;
   } entry_type;

   typedef struct packed {
      logic        status;
      logic [15:0] peer_port;
      logic [31:0] peer_addr;
      logic [30:0] duration;
      logic [30:0] process_id;
      logic [30:0] client_id;
   } result_type;

endpackage

// File: sv/pkst_link_store.sv
// Link memory of the session table: one next-node index per node.
// Runs the post-reset sweep that chains node i to node i plus one.
// Depends on nothing outside this file.
module pkst_link_store #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
   output logic [$clog2(TABLE_DEPTH):0]     rd_data,
   input  logic                             wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
   input  logic [$clog2(TABLE_DEPTH):0]     wr_data,
   output logic                             ready
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int LW = AW + 1;

   logic [LW-1:0] link_mem [TABLE_DEPTH];
   logic [LW-1:0] rd_data_ff;
   logic [LW-1:0] init_ff;
   logic [LW-1:0] init_in;
   logic          busy_ff;

   assign init_in = init_ff + LW'(1);
   assign rd_data = rd_data_ff;
   assign ready   = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         init_ff <= '0;
      end else if (busy_ff) begin
         init_ff <= init_in;
         if (init_ff == LW'(TABLE_DEPTH - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         link_mem[init_ff[AW-1:0]] <= init_in;
      end else if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= link_mem[rd_addr];
   end

endmodule

// File: sv/pkst_entry_store.sv
// Entry memory of the session table: key and payload of every node.
// Uses pkst_pkg::entry_type for the stored record.
// Contents are undefined until an add writes them.
module pkst_entry_store #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                             clock,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
   output pkst_pkg::entry_type              rd_data,
   input  logic                             wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
   input  pkst_pkg::entry_type              wr_data
);

   pkst_pkg::entry_type entry_mem [TABLE_DEPTH];
   pkst_pkg::entry_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

endmodule

// File: sv/pkst_seq.sv
// Operation sequencer of the session table: walks the linked list one
// node per cycle through the link and entry memories and writes back.
// Depends on pkst_pkg.
module pkst_seq #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  pkst_pkg::op_type                 req_op,
   input  pkst_pkg::entry_type              req_entry,
   input  logic                             link_ready,
   output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
   input  logic [$clog2(TABLE_DEPTH):0]     link_rd,
   input  pkst_pkg::entry_type              ent_rd,
   output logic                             link_we,
   output logic [$clog2(TABLE_DEPTH)-1:0]   link_wa,
   output logic [$clog2(TABLE_DEPTH):0]     link_wd,
   output logic                             ent_we,
   output logic [$clog2(TABLE_DEPTH)-1:0]   ent_wa,
   output pkst_pkg::entry_type              ent_wd,
   output logic                             res_valid,
   input  logic                             res_ready,
   output pkst_pkg::result_type             res
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int LW = AW + 1;
   localparam logic [LW-1:0] LNK_NONE = LW'(TABLE_DEPTH);

   pkst_pkg::state_type  state_ff, state_in;
   pkst_pkg::op_type     op_ff, op_in;
   pkst_pkg::entry_type  req_ff, req_in;
   pkst_pkg::result_type res_ff, res_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [LW-1:0]        count_ff, count_in;
   logic [LW-1:0]        node_ff, node_in;
   logic [LW-1:0]        prev_ff, prev_in;
   logic [LW-1:0]        steps_ff, steps_in;
   logic [AW-1:0]        rem_ff, rem_in;
   logic [AW-1:0]        last_ff, last_in;

   logic [LW-1:0]        steps_dec;
   logic                 nn_valid;
   logic                 key_hit;

   assign steps_dec = steps_ff - LW'(1);
   assign nn_valid  = link_rd < LNK_NONE;
   assign key_hit   = ent_rd.key == req_ff.key;
   assign req_ready = (state_ff == pkst_pkg::ST_IDLE) && link_ready;
   assign res       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pkst_pkg::ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      req_ff   <= req_in;
      res_ff   <= res_in;
      node_ff  <= node_in;
      prev_ff  <= prev_in;
      steps_ff <= steps_in;
      rem_ff   <= rem_in;
      last_ff  <= last_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      req_in    = req_ff;
      res_in    = res_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      node_in   = node_ff;
      prev_in   = prev_ff;
      steps_in  = steps_ff;
      rem_in    = rem_ff;
      last_in   = last_ff;
      rd_addr   = node_ff[AW-1:0];
      link_we   = 1'b0;
      link_wa   = '0;
      link_wd   = '0;
      ent_we    = 1'b0;
      ent_wa    = '0;
      ent_wd    = req_ff;
      res_valid = 1'b0;

      case (state_ff)
         pkst_pkg::ST_IDLE: begin
            if (req_valid && link_ready) begin
               op_in    = req_op;
               req_in   = req_entry;
               state_in = pkst_pkg::ST_START;
            end
         end

         pkst_pkg::ST_START: begin
            res_in        = '0;
            res_in.status = pkst_pkg::STATUS_ERR;
            node_in       = {1'b0, head_ff};
            prev_in       = LNK_NONE;
            steps_in      = count_ff;
            rd_addr       = head_ff;
            case (op_ff)
               pkst_pkg::OP_ADD: begin
                  if (count_ff >= LNK_NONE) begin
                     state_in = pkst_pkg::ST_RESP;
                  end else if (count_ff == '0) begin
                     ent_we        = 1'b1;
                     ent_wa        = head_ff;
                     count_in      = count_ff + LW'(1);
                     res_in.status = pkst_pkg::STATUS_OK;
                     state_in      = pkst_pkg::ST_RESP;
                  end else begin
                     state_in = pkst_pkg::ST_ADD_WALK;
                  end
               end
               default: begin
                  if (count_ff == '0) begin
                     state_in = pkst_pkg::ST_RESP;
                  end else begin
                     state_in = pkst_pkg::ST_FIND;
                  end
               end
            endcase
         end

         pkst_pkg::ST_ADD_WALK: begin
            if (!nn_valid) begin
               state_in = pkst_pkg::ST_RESP;
            end else if (steps_dec == '0) begin
               ent_we        = 1'b1;
               ent_wa        = link_rd[AW-1:0];
               count_in      = count_ff + LW'(1);
               res_in.status = pkst_pkg::STATUS_OK;
               state_in      = pkst_pkg::ST_RESP;
            end else begin
               rd_addr  = link_rd[AW-1:0];
               node_in  = link_rd;
               steps_in = steps_dec;
            end
         end

         pkst_pkg::ST_FIND: begin
            if (key_hit) begin
               res_in.status = pkst_pkg::STATUS_OK;
               state_in      = pkst_pkg::ST_RESP;
               case (op_ff)
                  pkst_pkg::OP_FETCH: begin
                     res_in.peer_port  = ent_rd.peer_port;
                     res_in.peer_addr  = ent_rd.peer_addr;
                     res_in.duration   = ent_rd.duration;
                     res_in.process_id = ent_rd.process_id;
                     res_in.client_id  = ent_rd.client_id;
                  end
                  pkst_pkg::OP_UPDATE: begin
                     ent_we = 1'b1;
                     ent_wa = node_ff[AW-1:0];
                  end
                  pkst_pkg::OP_REMOVE: begin
                     rem_in   = node_ff[AW-1:0];
                     count_in = count_ff - LW'(1);
                     state_in = pkst_pkg::ST_RM_START;
                     if (node_ff == {1'b0, head_ff}) begin
                        if (nn_valid) begin
                           head_in = link_rd[AW-1:0];
                        end
                     end else begin
                        link_we = 1'b1;
                        link_wa = prev_ff[AW-1:0];
                        link_wd = link_rd;
                     end
                  end
                  default: begin
                     res_in.status = pkst_pkg::STATUS_ERR;
                  end
               endcase
            end else if ((steps_dec == '0) || !nn_valid) begin
               state_in = pkst_pkg::ST_RESP;
            end else begin
               rd_addr  = link_rd[AW-1:0];
               prev_in  = node_ff;
               node_in  = link_rd;
               steps_in = steps_dec;
            end
         end

         pkst_pkg::ST_RM_START: begin
            rd_addr  = head_ff;
            node_in  = {1'b0, head_ff};
            steps_in = (count_ff == '0) ? '0 : count_ff - LW'(1);
            state_in = pkst_pkg::ST_RM_WALK;
         end

         pkst_pkg::ST_RM_WALK: begin
            if (steps_ff == '0) begin
               last_in = node_ff[AW-1:0];
               if (node_ff != {1'b0, rem_ff}) begin
                  link_we  = 1'b1;
                  link_wa  = rem_ff;
                  link_wd  = link_rd;
                  state_in = pkst_pkg::ST_RM_FIX;
               end else begin
                  state_in = pkst_pkg::ST_RESP;
               end
            end else if (!nn_valid) begin
               state_in = pkst_pkg::ST_RESP;
            end else begin
               rd_addr  = link_rd[AW-1:0];
               node_in  = link_rd;
               steps_in = steps_dec;
            end
         end

         pkst_pkg::ST_RM_FIX: begin
            link_we  = 1'b1;
            link_wa  = last_ff;
            link_wd  = {1'b0, rem_ff};
            state_in = pkst_pkg::ST_RESP;
         end

         pkst_pkg::ST_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = pkst_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pkst_pkg::ST_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LNK_NONE)
      else $error("active count beyond table depth");

   a_walk_node: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pkst_pkg::ST_FIND || state_ff == pkst_pkg::ST_ADD_WALK ||
       state_ff == pkst_pkg::ST_RM_WALK) |-> node_ff < LNK_NONE)
      else $error("walk reached a node outside the table");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pkst_pkg::ST_RM_START) |-> count_ff == $past(count_ff) - LW'(1))
      else $error("remove did not decrement the active count");

   a_head_change: assert property (@(posedge clock) disable iff (reset)
      !$stable(head_ff) |-> ($past(reset) || $past(state_ff) == pkst_pkg::ST_FIND))
      else $error("head moved outside a remove match");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> ($past(reset) || $past(state_ff) == pkst_pkg::ST_START ||
                              $past(state_ff) == pkst_pkg::ST_ADD_WALK ||
                              $past(state_ff) == pkst_pkg::ST_FIND))
      else $error("active count changed outside add or remove");

endmodule

// File: sv/port_keyed_session_table.sv
// Time from one accepted transaction to the next is set by the one-node-per-cycle
// list walk through the link and entry memory read ports and grows with active_count;
// an add on a full table does not walk, a remove walks the list twice. The result
// appears as req_tready rises again. One transaction is worked on at a time; a
// finished result waits in the output register. Reset: synchronous; a link sweep
// over all TABLE_DEPTH nodes follows, and req_tready stays low until it ends.
module port_keyed_session_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // port, peer_port, peer_addr, duration, process_id, client_id, zero pad
   input  logic [pkst_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op
   input  logic [pkst_pkg::OP_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // found_peer_port, found_peer_addr, found_duration, found_process_id,
   // found_client_id, zero pad
   output logic [pkst_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic                               rsp_tuser
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int LW = AW + 1;

   pkst_pkg::entry_type  req_entry;
   pkst_pkg::entry_type  ent_rd, ent_wd;
   pkst_pkg::result_type res, rsp_res_ff;
   logic [AW-1:0]        rd_addr, link_wa, ent_wa;
   logic [LW-1:0]        link_rd, link_wd;
   logic                 link_we, ent_we, link_ready;
   logic                 res_valid, res_ready;
   logic                 rsp_valid_ff;

   assign req_entry.key        = req_tdata[15:0];
   assign req_entry.peer_port  = req_tdata[31:16];
   assign req_entry.peer_addr  = req_tdata[63:32];
   assign req_entry.duration   = req_tdata[94:64];
   assign req_entry.process_id = req_tdata[125:95];
   assign req_entry.client_id  = req_tdata[156:126];

   assign res_ready  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = {3'b000, rsp_res_ff.client_id, rsp_res_ff.process_id,
                        rsp_res_ff.duration, rsp_res_ff.peer_addr,
                        rsp_res_ff.peer_port};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_res_ff <= res;
      end
   end

   pkst_link_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_link (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (link_rd),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .ready   (link_ready)
   );

   pkst_entry_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_entry (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (ent_rd),
      .wr_en   (ent_we),
      .wr_addr (ent_wa),
      .wr_data (ent_wd)
   );

   pkst_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (pkst_pkg::op_type'(req_tuser)),
      .req_entry  (req_entry),
      .link_ready (link_ready),
      .rd_addr    (rd_addr),
      .link_rd    (link_rd),
      .ent_rd     (ent_rd),
      .link_we    (link_we),
      .link_wa    (link_wa),
      .link_wd    (link_wd),
      .ent_we     (ent_we),
      .ent_wa     (ent_wa),
      .ent_wd     (ent_wd),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

endmodule
